@@ rtl/msix_vector_allocator_macros.svh @@
// Assertion macros shared by the checker of the MSI-X vector allocator.
`ifndef MSIX_VECTOR_ALLOCATOR_MACROS_SVH
`define MSIX_VECTOR_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSXVA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msxva: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MSXVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msxva: next-cycle check failed");

`endif

@@ rtl/msxva_pkg.sv @@
// Types, codes and constants shared by the MSI-X vector allocator files.
`default_nettype none

package msxva_pkg;

  // Default depth of the vector table.
  localparam int MAX_VECTORS_DEF = 64;
  // Largest value the table size register can encode.
  localparam int SIZE_MAX = 127;
  // Index width able to address every entry the size register can reach.
  localparam int IDX_W_MAX = 7;

  localparam logic [6:0]  TABLE_SIZE_RST = 7'd64;
  localparam logic [7:0]  APIC_ID_RST    = 8'd0;
  localparam logic [31:0] MSG_ADDR_BASE  = 32'hFEE0_0000;
  localparam int          APIC_SHIFT     = 12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [0:0] CFG_TABLE_SIZE = 1'b0;
  localparam logic [0:0] CFG_APIC_ID    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_HANDLER = 2'd1,
    ST_FULL       = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef struct packed {
    logic        opcode;
    logic        handler_valid;
    logic [7:0]  irq_number;
    logic [10:0] free_vector;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  granted_vector;
    logic [31:0] address_low;
    logic [7:0]  message_value;
    logic        entry_masked;
  } rsp_t;

  typedef struct packed {
    logic [7:0] destination;
    logic [7:0] data;
    logic       mask;
  } entry_t;

  typedef struct packed {
    logic                 en;
    logic                 set;
    logic [IDX_W_MAX-1:0] idx;
  } map_upd_t;

  typedef struct packed {
    logic                 found;
    logic [IDX_W_MAX-1:0] idx;
  } map_res_t;

endpackage

`default_nettype wire

@@ rtl/msxva_free_map.sv @@
// Used flags of the vector table and the two-level lowest-free-entry search.
`default_nettype none

module msxva_free_map #(
  parameter int NUM_ENTRIES = msxva_pkg::MAX_VECTORS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [6:0]         table_size,
  input  wire msxva_pkg::map_upd_t upd,
  output msxva_pkg::map_res_t      res
);

  localparam int GRP   = 8;
  localparam int OFF_W = $clog2(GRP);
  localparam int NGRP  = (NUM_ENTRIES + GRP - 1) / GRP;
  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  logic [NUM_ENTRIES-1:0] used_r, used_nxt;
  logic [NGRP*GRP-1:0]    used_pad;
  logic [NGRP-1:0]        grp_any_r, grp_any_nxt;
  logic [OFF_W-1:0]       grp_off_r   [NGRP];
  logic [OFF_W-1:0]       grp_off_nxt [NGRP];

  always_comb begin
    used_nxt = used_r;
    if (upd.en) begin
      used_nxt[upd.idx[IDX_W-1:0]] = upd.set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // First level: lowest free entry within each group of eight.
  // Padding entries count as used.
  always_comb begin
    used_pad = '1;
    used_pad[NUM_ENTRIES-1:0] = used_r;
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_off_nxt[g] = '0;
      for (int b = GRP - 1; b >= 0; b--) begin
        if (!used_pad[g*GRP+b] && (7'(g*GRP+b) < table_size)) begin
          grp_any_nxt[g] = 1'b1;
          grp_off_nxt[g] = OFF_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    grp_off_r <= grp_off_nxt;
  end

  // Second level: lowest group holding a free entry.
  always_comb begin
    res = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        res.found = 1'b1;
        res.idx   = msxva_pkg::IDX_W_MAX'(g*GRP) | msxva_pkg::IDX_W_MAX'(grp_off_r[g]);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/msxva_entry_table.sv @@
// Vector table memory: one write port and one registered read port.
`default_nettype none

module msxva_entry_table #(
  parameter int NUM_ENTRIES = msxva_pkg::MAX_VECTORS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [msxva_pkg::IDX_W_MAX-1:0]   waddr,
  input  wire msxva_pkg::entry_t                 wdata,
  input  wire logic                              re,
  input  wire logic [msxva_pkg::IDX_W_MAX-1:0]   raddr,
  output msxva_pkg::entry_t                      rdata
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  msxva_pkg::entry_t mem [NUM_ENTRIES];
  msxva_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[IDX_W-1:0]] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr[IDX_W-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/msix_vector_allocator.sv @@
// MSI-X vector allocator: allocates and frees entries of an MSI-X vector table.
//
// Each request either allocates the lowest free table entry below the
// configured table size (opcode 0) or frees a given entry (opcode 1). It
// returns exactly one result. A request passes through S_SRCH, S_READ and
// S_DONE before its result is loaded into the output register. The first
// level of the free-entry search, one level per group of eight used flags,
// is registered every cycle, so it is already settled at the acceptance
// edge. In S_SRCH the block finishes the search over the groups and writes
// the entry table. In S_READ it reads the entry back through the table's
// registered read port, and in S_DONE it loads the result and returns to
// idle. It must be idle to accept the next request, so it cannot take a
// new request before it is through with the last one. The output register
// lets the next request be accepted while an earlier result is still
// waiting to be taken. A result that cannot yet be loaded holds the block
// in its last step, which stalls the input for as long as the result side
// stalls. The used flags are flip-flops cleared by reset, so the table
// needs no clearing pass and is ready in the first cycle after reset.
// Table size and APIC id must only be written while the block is idle.
`default_nettype none

module msix_vector_allocator #(
  parameter int MAX_VECTORS = msxva_pkg::MAX_VECTORS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire msxva_pkg::req_t in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output msxva_pkg::rsp_t      out_data,
  input  wire logic            cfg_we,
  input  wire logic [0:0]      cfg_index,
  input  wire logic [7:0]      cfg_wdata
);

  // Entries beyond the largest encodable table size can never be reached.
  localparam int REACH = (MAX_VECTORS < msxva_pkg::SIZE_MAX) ? MAX_VECTORS
                                                            : msxva_pkg::SIZE_MAX;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SRCH = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } fsm_t;

  fsm_t                                state_r, state_nxt;
  logic [6:0]                          table_size_r, table_size_nxt;
  logic [7:0]                          apic_id_r, apic_id_nxt;
  msxva_pkg::req_t                     req_r;
  msxva_pkg::status_t                  status_r, status_nxt;
  logic [msxva_pkg::IDX_W_MAX-1:0]     idx_r, idx_nxt;
  logic                                out_valid_r, out_valid_nxt;
  msxva_pkg::rsp_t                     out_data_r, out_data_nxt;

  logic                                in_accept;
  logic                                out_load;
  logic                                free_in_range;
  msxva_pkg::map_upd_t                 map_upd;
  msxva_pkg::map_res_t                 map_res;
  logic                                tbl_we;
  msxva_pkg::entry_t                   tbl_wdata;
  logic                                tbl_re;
  msxva_pkg::entry_t                   tbl_rdata;

  msxva_free_map #(
    .NUM_ENTRIES (REACH)
  ) u_free_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .table_size (table_size_r),
    .upd        (map_upd),
    .res        (map_res)
  );

  msxva_entry_table #(
    .NUM_ENTRIES (REACH)
  ) u_entry_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (idx_nxt),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (idx_r),
    .rdata (tbl_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A free must name an index below both the table size and the table depth.
  assign free_in_range = ({4'b0000, table_size_r} > req_r.free_vector) &&
                         (req_r.free_vector < 11'(REACH));

  // Configuration writes.
  always_comb begin
    table_size_nxt = table_size_r;
    apic_id_nxt    = apic_id_r;
    if (cfg_we) begin
      case (cfg_index)
        msxva_pkg::CFG_TABLE_SIZE: table_size_nxt = cfg_wdata[6:0];
        msxva_pkg::CFG_APIC_ID:    apic_id_nxt    = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Request sequencer.
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    map_upd    = '0;
    tbl_we     = 1'b0;
    tbl_wdata  = '0;
    tbl_re     = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        // The search result, the used flag and the table write all settle here.
        state_nxt = S_READ;
        idx_nxt   = '0;
        if (req_r.opcode == msxva_pkg::OP_ALLOC) begin
          if (!req_r.handler_valid) begin
            status_nxt = msxva_pkg::ST_NO_HANDLER;
          end else if (!map_res.found) begin
            status_nxt = msxva_pkg::ST_FULL;
          end else begin
            status_nxt            = msxva_pkg::ST_OK;
            idx_nxt               = map_res.idx;
            map_upd.en            = 1'b1;
            map_upd.set           = 1'b1;
            map_upd.idx           = map_res.idx;
            tbl_we                = 1'b1;
            tbl_wdata.destination = apic_id_r;
            tbl_wdata.data        = req_r.irq_number;
            tbl_wdata.mask        = 1'b0;
          end
        end else begin
          if (free_in_range) begin
            status_nxt     = msxva_pkg::ST_OK;
            idx_nxt        = req_r.free_vector[msxva_pkg::IDX_W_MAX-1:0];
            map_upd.en     = 1'b1;
            map_upd.set    = 1'b0;
            map_upd.idx    = req_r.free_vector[msxva_pkg::IDX_W_MAX-1:0];
            tbl_we         = 1'b1;
            tbl_wdata.mask = 1'b1;
          end else begin
            status_nxt = msxva_pkg::ST_RANGE;
          end
        end
      end
      S_READ: begin
        // Read back the entry just written; only successful requests need it.
        tbl_re    = (status_r == msxva_pkg::ST_OK);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result formation. A failed request reports zeros in every field but status.
  // An unmasked entry is in use and carries the full message address.
  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt.status = status_r;
    if (status_r == msxva_pkg::ST_OK) begin
      out_data_nxt.granted_vector = 6'(idx_r);
      out_data_nxt.message_value  = tbl_rdata.data;
      out_data_nxt.entry_masked   = tbl_rdata.mask;
      if (!tbl_rdata.mask) begin
        out_data_nxt.address_low = msxva_pkg::MSG_ADDR_BASE |
                                   (32'(tbl_rdata.destination) << msxva_pkg::APIC_SHIFT);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      table_size_r <= msxva_pkg::TABLE_SIZE_RST;
      apic_id_r    <= msxva_pkg::APIC_ID_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      table_size_r <= table_size_nxt;
      apic_id_r    <= apic_id_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= in_data;
    end
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/msxva_checker.sv @@
// Port-level checker for the MSI-X vector allocator and its bind statement.
`default_nettype none

`include "msix_vector_allocator_macros.svh"

module msxva_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_stall,
  input wire logic            out_valid,
  input wire logic            out_stall,
  input wire msxva_pkg::rsp_t out_data
);

  // A failed request carries nothing but its status.
  `MSXVA_ASSERT_SAME(a_fail_zero, clk, rst_n, out_valid && (out_data.status != msxva_pkg::ST_OK), (out_data.granted_vector == 6'd0) && (out_data.address_low == 32'd0) && (out_data.message_value == 8'd0) && !out_data.entry_masked)

  // A freed entry is masked and holds neither address nor data.
  `MSXVA_ASSERT_SAME(a_free_clear, clk, rst_n, out_valid && (out_data.status == msxva_pkg::ST_OK) && out_data.entry_masked, (out_data.address_low == 32'd0) && (out_data.message_value == 8'd0))

  // An allocated entry points at the local APIC window.
  `MSXVA_ASSERT_SAME(a_alloc_addr, clk, rst_n, out_valid && (out_data.status == msxva_pkg::ST_OK) && !out_data.entry_masked, (out_data.address_low[31:20] == 12'hFEE) && (out_data.address_low[11:0] == 12'h000))

  // Requests are handled one at a time.
  `MSXVA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)

  // A stalled result is held.
  `MSXVA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind msix_vector_allocator msxva_checker u_msxva_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
